// ===== sv/cspm_pkg.sv =====
`default_nettype none

package cspm_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ROW_W  = 8;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_LOAD  = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_PTR_A,
    S_PTR_B,
    S_PTR_C,
    S_PTR_D,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS,
    S_BUMP_RD,
    S_BUMP_WR,
    S_MUL_RD,
    S_MUL_VEC,
    S_MUL_PROD,
    S_MUL_ACC,
    S_MUL_FIN,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/cspm_mac.sv =====
`default_nettype none

module cspm_mac
  import cspm_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  wire logic                    clk_i,
  input  wire mac_ctrl_t               ctrl_i,
  input  wire logic signed [VAL_W-1:0] a_i,
  input  wire logic signed [VAL_W-1:0] b_i,
  output logic signed [VAL_W-1:0]      result_o
);

  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_ENTRIES) + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shf;
  logic                     fits;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round to nearest, ties up, then saturate
  always_comb begin
    rnd  = acc_q + ACC_W'(32768);
    shf  = rnd >>> 16;
    fits = (&shf[ACC_W-1:VAL_W-1]) || !(|shf[ACC_W-1:VAL_W-1]);
    if (fits) begin
      result_o = shf[VAL_W-1:0];
    end else if (shf[ACC_W-1]) begin
      result_o = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== sv/csr_sparse_matrix_store.sv =====
`default_nettype none

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-------------------------------
// command  | in        | in_valid_i / in_stall_o  | cmd_i, row_i, col_i, value_i
// result   | out       | out_valid_o / out_stall_i| result_o, status_o
// config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One transaction at a time. A load or an error goes straight to the result. A get or set reads
// the row pointers, then scans the row's entries in column order; a set miss with room left shifts
// each later entry up by one, writes the new entry and bumps every later row pointer. Row multiply
// reads, multiplies and accumulates each entry of the row in turn; clear zeroes every row pointer.
// Each memory has one read and one write port. After reset a sweep zeroes the pointer and vector
// memories with in_stall_o high. A stalled result holds; the next command is taken while it waits.

module csr_sparse_matrix_store
  import cspm_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [CMD_W-1:0]         cmd_i,
  input  wire logic [ROW_W-1:0]         row_i,
  input  wire logic [COL_W-1:0]         col_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [VAL_W-1:0]       result_o,
  output logic [STAT_W-1:0]             status_o,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned PTR_W      = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EA_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned RS_W       = $clog2(MAX_ROWS + 1);
  localparam int unsigned DA_W       = $clog2(MAX_COLS);
  localparam int unsigned SWEEP_LAST = (MAX_ROWS > MAX_COLS - 1) ? MAX_ROWS : MAX_COLS - 1;
  localparam int unsigned SW_W       = $clog2(SWEEP_LAST + 1);

  logic [PTR_W-1:0] rs_mem [MAX_ROWS+1];
  logic [COL_W-1:0] ci_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] ev_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] dv_mem [MAX_COLS];

  state_e state_q, state_d;

  logic [CFG_W-1:0]  num_rows_q, num_cols_q;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [PTR_W-1:0]  start_q, start_d, end_q, end_d, total_q, total_d;
  logic [PTR_W-1:0]  n_q, n_d, k_q, k_d;
  logic [RS_W-1:0]   bump_q, bump_d;
  logic [SW_W-1:0]   sweep_q, sweep_d;
  logic [VAL_W-1:0]  evh_q, evh_d;
  logic              cin_q, cin_d;
  logic [VAL_W-1:0]  res_q, res_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_res_q, out_res_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;

  logic             rs_we;
  logic [RS_W-1:0]  rs_waddr, rs_raddr;
  logic [PTR_W-1:0] rs_wdata, rs_rdata_q;
  logic             ent_we;
  logic [EA_W-1:0]  ent_waddr, ent_raddr;
  logic [COL_W-1:0] ci_wdata, ci_rdata_q;
  logic [VAL_W-1:0] ev_wdata, ev_rdata_q;
  logic             dv_we;
  logic [DA_W-1:0]  dv_waddr, dv_raddr;
  logic [VAL_W-1:0] dv_wdata, dv_rdata_q;

  logic [31:0]      nr, nc;
  logic             row_ok, col_ok, accept;
  logic [31:0]      sweep_ext;
  mac_ctrl_t        mac_ctrl;
  logic signed [VAL_W-1:0] mac_b, mac_res;

  function automatic logic [PTR_W-1:0] bound_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (32'(p) > MAX_ENTRIES) ? PTR_W'(MAX_ENTRIES) : p;
    return r;
  endfunction

  cspm_mac #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .a_i     (evh_q),
    .b_i     (mac_b),
    .result_o(mac_res)
  );

  assign mac_b = cin_q ? dv_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    rs_rdata_q <= rs_mem[rs_raddr];
    if (ent_we) begin
      ci_mem[ent_waddr] <= ci_wdata;
      ev_mem[ent_waddr] <= ev_wdata;
    end
    ci_rdata_q <= ci_mem[ent_raddr];
    ev_rdata_q <= ev_mem[ent_raddr];
    if (dv_we) begin
      dv_mem[dv_waddr] <= dv_wdata;
    end
    dv_rdata_q <= dv_mem[dv_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= CFG_W'(256);
      num_cols_q <= CFG_W'(256);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM_ROWS) begin
        num_rows_q <= cfg_data_i;
      end else begin
        num_cols_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    nr = (num_rows_q == '0) ? 32'd1 :
         (32'(num_rows_q) > MAX_ROWS) ? 32'(MAX_ROWS) : 32'(num_rows_q);
    nc = (num_cols_q == '0) ? 32'd1 :
         (32'(num_cols_q) > MAX_COLS) ? 32'(MAX_COLS) : 32'(num_cols_q);
    row_ok = 32'(row_i) < nr;
    col_ok = 32'(col_i) < nc;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_res_q;
  assign status_o    = out_stat_q;
  assign sweep_ext   = 32'(sweep_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    row_q      <= row_d;
    col_q      <= col_d;
    val_q      <= val_d;
    start_q    <= start_d;
    end_q      <= end_d;
    total_q    <= total_d;
    n_q        <= n_d;
    k_q        <= k_d;
    bump_q     <= bump_d;
    evh_q      <= evh_d;
    cin_q      <= cin_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    val_d       = val_q;
    start_d     = start_q;
    end_d       = end_q;
    total_d     = total_q;
    n_d         = n_q;
    k_d         = k_q;
    bump_d      = bump_q;
    sweep_d     = sweep_q;
    evh_d       = evh_q;
    cin_d       = cin_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    rs_we       = 1'b0;
    rs_waddr    = RS_W'(sweep_ext);
    rs_wdata    = '0;
    rs_raddr    = '0;
    ent_we      = 1'b0;
    ent_waddr   = n_q[EA_W-1:0];
    ent_raddr   = n_q[EA_W-1:0];
    ci_wdata    = col_q;
    ev_wdata    = val_q;
    dv_we       = 1'b0;
    dv_waddr    = DA_W'(sweep_ext);
    dv_wdata    = '0;
    dv_raddr    = DA_W'(32'(ci_rdata_q));
    mac_ctrl    = '0;

    unique case (state_q)
      S_INIT: begin
        rs_we = (sweep_ext <= MAX_ROWS);
        dv_we = (sweep_ext < MAX_COLS);
        if (sweep_ext == SWEEP_LAST) begin
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_i;
          row_d  = row_i;
          col_d  = col_i;
          val_d  = value_i;
          res_d  = '0;
          stat_d = ST_OK;
          case (cmd_i)
            CMD_SET, CMD_GET: begin
              if (row_ok && col_ok) begin
                state_d = S_PTR_A;
              end else begin
                stat_d  = ST_RANGE;
                state_d = S_DONE;
              end
            end
            CMD_LOAD: begin
              if (col_ok) begin
                dv_we    = 1'b1;
                dv_waddr = DA_W'(32'(col_i));
                dv_wdata = value_i;
              end else begin
                stat_d = ST_RANGE;
              end
              state_d = S_DONE;
            end
            CMD_MUL: begin
              if (row_ok) begin
                state_d = S_PTR_A;
              end else begin
                stat_d  = ST_RANGE;
                state_d = S_DONE;
              end
            end
            CMD_CLEAR: begin
              sweep_d = '0;
              state_d = S_CLEAR;
            end
            default: begin
              stat_d  = ST_RANGE;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_PTR_A: begin
        rs_raddr = RS_W'(32'(row_q));
        state_d  = S_PTR_B;
      end
      S_PTR_B: begin
        rs_raddr = RS_W'(32'(row_q) + 32'd1);
        start_d  = bound_ptr(rs_rdata_q);
        state_d  = S_PTR_C;
      end
      S_PTR_C: begin
        rs_raddr = RS_W'(MAX_ROWS);
        end_d    = bound_ptr(rs_rdata_q);
        n_d      = start_q;
        state_d  = S_PTR_D;
      end
      S_PTR_D: begin
        total_d      = bound_ptr(rs_rdata_q);
        mac_ctrl.clr = 1'b1;
        state_d      = (cmd_q == CMD_MUL) ? S_MUL_RD : S_SRCH_RD;
      end
      S_SRCH_RD: begin
        state_d = (n_q < end_q) ? S_SRCH_CHK : S_MISS;
      end
      S_SRCH_CHK: begin
        if (ci_rdata_q < col_q) begin
          n_d     = n_q + 1'b1;
          state_d = S_SRCH_RD;
        end else if (ci_rdata_q == col_q) begin
          if (cmd_q == CMD_GET) begin
            res_d = ev_rdata_q;
          end else begin
            ent_we   = 1'b1;
            ci_wdata = col_q;
          end
          state_d = S_DONE;
        end else begin
          state_d = S_MISS;
        end
      end
      S_MISS: begin
        k_d = total_q;
        if (cmd_q == CMD_GET) begin
          stat_d  = ST_ABSENT;
          state_d = S_DONE;
        end else if (32'(total_q) >= MAX_ENTRIES) begin
          stat_d  = ST_FULL;
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        ent_raddr = EA_W'(k_q - 1'b1);
        state_d   = (k_q > n_q) ? S_SHIFT_WR : S_INS;
      end
      S_SHIFT_WR: begin
        ent_we    = 1'b1;
        ent_waddr = k_q[EA_W-1:0];
        ci_wdata  = ci_rdata_q;
        ev_wdata  = ev_rdata_q;
        k_d       = k_q - 1'b1;
        state_d   = S_SHIFT_RD;
      end
      S_INS: begin
        ent_we  = 1'b1;
        bump_d  = RS_W'(32'(row_q) + 32'd1);
        state_d = S_BUMP_RD;
      end
      S_BUMP_RD: begin
        rs_raddr = bump_q;
        state_d  = S_BUMP_WR;
      end
      S_BUMP_WR: begin
        rs_we    = 1'b1;
        rs_waddr = bump_q;
        rs_wdata = rs_rdata_q + 1'b1;
        if (32'(bump_q) == MAX_ROWS) begin
          state_d = S_DONE;
        end else begin
          bump_d  = bump_q + 1'b1;
          state_d = S_BUMP_RD;
        end
      end
      S_MUL_RD: begin
        state_d = (n_q < end_q) ? S_MUL_VEC : S_MUL_FIN;
      end
      S_MUL_VEC: begin
        evh_d   = ev_rdata_q;
        cin_d   = 32'(ci_rdata_q) < MAX_COLS;
        state_d = S_MUL_PROD;
      end
      S_MUL_PROD: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        n_d             = n_q + 1'b1;
        state_d         = S_MUL_RD;
      end
      S_MUL_FIN: begin
        res_d   = mac_res;
        state_d = S_DONE;
      end
      S_CLEAR: begin
        rs_we = 1'b1;
        if (sweep_ext == MAX_ROWS) begin
          state_d = S_DONE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_stat_d  = stat_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/csr_sparse_matrix_store_check.sv =====
`timescale 1ns / 1ps

module csr_sparse_matrix_store_check
  import cspm_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_o,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [COL_W-1:0]        col_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic signed [VAL_W-1:0] result_o,
  input  logic [STAT_W-1:0]       status_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output int                      pending_o,
  output int                      errors_o
);

  typedef struct packed {
    logic [VAL_W-1:0]  result;
    logic [STAT_W-1:0] status;
  } answer_t;

  answer_t          answers_q[$];
  int               row_start[0:MAX_ROWS];
  logic [COL_W-1:0] col_index[0:MAX_ENTRIES-1];
  logic [VAL_W-1:0] entry_value[0:MAX_ENTRIES-1];
  logic [VAL_W-1:0] dense_vector[0:MAX_COLS-1];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic answer_t execute(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                      logic [COL_W-1:0] col, logic [VAL_W-1:0] val);
    answer_t           ans;
    int                nr;
    int                nc;
    int                first;
    int                last;
    int                n;
    int                total;
    logic              hit;
    logic signed [63:0] prod;
    logic signed [95:0] acc;
    nr = clamp_dim(rows_reg, MAX_ROWS);
    nc = clamp_dim(cols_reg, MAX_COLS);
    ans.result = '0;
    ans.status = ST_OK;
    case (cmd)
      CMD_SET, CMD_GET: begin
        if (row >= nr || col >= nc) begin
          ans.status = ST_RANGE;
        end else begin
          first = row_start[row];
          last  = row_start[row + 1];
          n = first;
          while (n < last && col_index[n] < col) n++;
          hit = (n < last) && (col_index[n] == col);
          if (cmd == CMD_GET) begin
            if (hit) ans.result = entry_value[n];
            else ans.status = ST_ABSENT;
          end else if (hit) begin
            entry_value[n] = val;
          end else begin
            total = row_start[MAX_ROWS];
            if (total >= MAX_ENTRIES) begin
              ans.status = ST_FULL;
            end else begin
              for (int k = total; k > n; k--) begin
                col_index[k]   = col_index[k - 1];
                entry_value[k] = entry_value[k - 1];
              end
              col_index[n]   = col;
              entry_value[n] = val;
              for (int k = row + 1; k <= MAX_ROWS; k++) row_start[k]++;
            end
          end
        end
      end
      CMD_LOAD: begin
        if (col >= nc) ans.status = ST_RANGE;
        else dense_vector[col] = val;
      end
      CMD_MUL: begin
        if (row >= nr) begin
          ans.status = ST_RANGE;
        end else begin
          acc = '0;
          for (n = row_start[row]; n < row_start[row + 1]; n++) begin
            prod = $signed(entry_value[n]) * $signed(dense_vector[col_index[n]]);
            acc  = acc + prod;
          end
          acc = (acc + 96'sd32768) >>> 16;
          if (acc > 96'sh7FFF_FFFF) ans.result = 32'h7FFF_FFFF;
          else if (acc < -96'sh8000_0000) ans.result = 32'h8000_0000;
          else ans.result = acc[31:0];
        end
      end
      CMD_CLEAR: begin
        for (int k = 0; k <= MAX_ROWS; k++) row_start[k] = 0;
      end
      default: ans.status = ST_RANGE;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int k = 0; k <= MAX_ROWS; k++) row_start[k] = 0;
      for (int k = 0; k < MAX_COLS; k++) dense_vector[k] = '0;
      rows_reg = 9'd256;
      cols_reg = 9'd256;
      answers_q.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_ROWS) rows_reg = cfg_data_i;
        else cols_reg = cfg_data_i;
      end
      if (out_valid_o && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result %h status %0d", $time, result_o, status_o);
          errors_o++;
        end else begin
          want = answers_q.pop_front();
          if (result_o !== want.result) begin
            $display("%0t: result expected %h actual %h", $time, want.result, result_o);
            errors_o++;
          end
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        answers_q.push_back(execute(cmd_i, row_i, col_i, value_i));
      pending_o = answers_q.size();
    end
  end

endmodule

// ===== tb/csr_sparse_matrix_store_test.sv =====
`timescale 1ns / 1ps

module csr_sparse_matrix_store_test;
  import cspm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        cmd_i;
  logic [ROW_W-1:0]        row_i;
  logic [COL_W-1:0]        col_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] result_o;
  logic [STAT_W-1:0]       status_o;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;
  int                      pending;
  int                      errors;
  int                      sent;
  int                      settings;
  int                      taken;
  int                      rx_gap;
  logic                    rx_calm;
  logic                    tx_calm;
  int                      eff_rows;
  int                      eff_cols;

  csr_sparse_matrix_store i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .row_i, .col_i, .value_i,
    .out_valid_o, .out_stall_i, .result_o, .status_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  csr_sparse_matrix_store_check i_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .row_i, .col_i, .value_i,
    .out_valid_o, .out_stall_i, .result_o, .status_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(64'd400_000_000);
    $display("csr_sparse_matrix_store test failed");
    $finish;
  end

  // receiver: random stall per result, calm stretches, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_gap      = 0;
      rx_calm     = 1'b0;
      taken       = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        taken++;
        if ($urandom_range(0, 40) == 0) rx_calm = ~rx_calm;
        rx_gap = rx_calm ? 0 : $urandom_range(0, 19);
        if (taken == 150) rx_gap = 400;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      out_stall_i <= (rx_gap != 0);
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                      logic [COL_W-1:0] col, logic [VAL_W-1:0] val, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i      <= cmd;
    row_i      <= row;
    col_i      <= col;
    value_i    <= val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_NUM_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NUM_COLS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    eff_rows = rows == 0 ? 1 : (rows > 256 ? 256 : rows);
    eff_cols = cols == 0 ? 1 : (cols > 256 ? 256 : cols);
    settings++;
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 40) == 0) tx_calm = ~tx_calm;
    return tx_calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic random_items(int count);
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_SET;
      else if (pick < 60) cmd = CMD_GET;
      else if (pick < 75) cmd = CMD_LOAD;
      else if (pick < 95) cmd = CMD_MUL;
      else if (pick < 97) cmd = CMD_CLEAR;
      else cmd = CMD_W'($urandom_range(CMD_RSV5, CMD_RSV7));
      row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(0, 255)) :
                                          ROW_W'($urandom_range(0, eff_rows - 1));
      col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(0, 255)) :
                                          COL_W'($urandom_range(0, eff_cols - 1));
      val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h3_FFFF) - 32'h2_0000 : $urandom;
      send(cmd, row, col, val, draw_gap());
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    cmd_i      = CMD_GET;
    row_i      = '0;
    col_i      = '0;
    value_i    = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_NUM_ROWS;
    cfg_data_i = '0;
    sent       = 0;
    settings   = 1;
    tx_calm    = 1'b0;
    eff_rows   = 256;
    eff_cols   = 256;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_LOAD, 8'd0, 8'd255, 32'h7FFF_FFFF, 0);
    send(CMD_LOAD, 8'd0, 8'd0, 32'h8000_0000, 0);
    send(CMD_LOAD, 8'd0, 8'd1, 32'h7FFF_FFFF, 3);
    send(CMD_SET, 8'd255, 8'd255, 32'h7FFF_FFFF, 0);
    send(CMD_SET, 8'd0, 8'd0, 32'h8000_0000, 1);
    send(CMD_SET, 8'd0, 8'd255, 32'h0001_8000, 0);
    send(CMD_SET, 8'd0, 8'd1, 32'h7FFF_FFFF, 0);
    send(CMD_GET, 8'd0, 8'd0, '0, 2);
    send(CMD_GET, 8'd1, 8'd1, '0, 0);
    send(CMD_MUL, 8'd0, 8'd0, '0, 0);
    send(CMD_MUL, 8'd255, 8'd0, '0, 5);
    send(CMD_MUL, 8'd7, 8'd0, '0, 0);
    send(CMD_SET, 8'd0, 8'd0, 32'hFFFF_0000, 0);
    send(CMD_MUL, 8'd0, 8'd0, '0, 0);
    send(CMD_RSV5, 8'd3, 8'd3, 32'hFFFF_FFFF, 0);
    send(CMD_RSV6, 8'd0, 8'd0, '0, 0);
    send(CMD_RSV7, 8'd255, 8'd255, '0, 1);
    configure(9'd0, 9'd0);
    send(CMD_SET, 8'd1, 8'd0, 32'h1, 0);
    send(CMD_GET, 8'd0, 8'd1, '0, 0);
    send(CMD_LOAD, 8'd0, 8'd1, 32'h1, 0);
    send(CMD_MUL, 8'd1, 8'd0, '0, 0);
    send(CMD_MUL, 8'd0, 8'd0, '0, 0);
    send(CMD_CLEAR, 8'd0, 8'd0, '0, 0);
    send(CMD_GET, 8'd0, 8'd0, '0, 0);

    // insert in descending column order so that every insert after a row's first shifts entries
    configure(9'd32, 9'd33);
    for (int r = 0; r < 4; r++)
      for (int c = 7; c >= 0; c--)
        send(CMD_SET, ROW_W'(r), COL_W'(c), $urandom, 0);
    send(CMD_SET, 8'd0, 8'd32, 32'h1234_5678, 0);
    send(CMD_SET, 8'd2, 8'd5, 32'h0002_0000, 0);
    send(CMD_GET, 8'd2, 8'd5, '0, 0);
    send(CMD_MUL, 8'd3, 8'd0, '0, 0);
    send(CMD_CLEAR, 8'd0, 8'd0, '0, 0);

    configure(9'd16, 9'd16);
    random_items(150);
    configure(9'd1, 9'd1);
    random_items(40);
    configure(9'd300, 9'd511);
    random_items(150);
    configure(9'd8, 9'd200);
    random_items(100);
    configure(9'd64, 9'd8);
    random_items(120);
    configure(9'd256, 9'd256);
    random_items(200);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d commands over %0d register settings, with shifting inserts,",
             sent, settings);
    $display("range errors, absent reads, clears and saturated row products.");
    if (errors == 0) $display("csr_sparse_matrix_store test passed");
    else $display("csr_sparse_matrix_store test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cspm_pkg.sv
sv/cspm_mac.sv
sv/csr_sparse_matrix_store.sv
tb/csr_sparse_matrix_store_check.sv
tb/csr_sparse_matrix_store_test.sv
